>>> src/nlbc_pkg.sv
// Shared constants, character codes and helper functions of the number literal classifier.
package nlbc_pkg;

    // Longest token that still gets classified.
    localparam int MAX_TOKEN_LEN = 64;

    // The character counter saturates at MAX_TOKEN_LEN + 1.
    localparam int CNT_W = $clog2(MAX_TOKEN_LEN + 2);

    // Field widths of one input item and one result item.
    localparam int CHAR_W  = 8;
    localparam int RADIX_W = 5;
    localparam int START_W = 2;
    localparam int LEN_W   = 7;
    localparam int RES_W   = RADIX_W + START_W + LEN_W;
    localparam int RES_TDATA_W = ((RES_W + 7) / 8) * 8;

    // Width used to form digit lengths before they are cut to LEN_W.
    localparam int EXT_W = (CNT_W + 1 > LEN_W) ? CNT_W + 1 : LEN_W;

    // Radix codes.
    localparam logic [RADIX_W-1:0] RADIX_NONE = 5'd0;
    localparam logic [RADIX_W-1:0] RADIX_BIN  = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_DEC  = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX  = 5'd16;

    // Digit start offsets.
    localparam logic [START_W-1:0] START_NONE   = 2'd0;
    localparam logic [START_W-1:0] START_MARK   = 2'd1;
    localparam logic [START_W-1:0] START_PREFIX = 2'd2;

    // ASCII codes of the marker characters.
    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] CH_ONE     = 8'h31;
    localparam logic [CHAR_W-1:0] CH_LO_B    = 8'h62;
    localparam logic [CHAR_W-1:0] CH_UP_B    = 8'h42;
    localparam logic [CHAR_W-1:0] CH_LO_H    = 8'h68;
    localparam logic [CHAR_W-1:0] CH_UP_H    = 8'h48;
    localparam logic [CHAR_W-1:0] CH_LO_X    = 8'h78;
    localparam logic [CHAR_W-1:0] CH_UP_X    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_UP_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UP_F    = 8'h46;
    localparam logic [CHAR_W-1:0] CH_LO_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LO_F    = 8'h66;

    // Character class tests.
    function automatic logic is_bin(input logic [CHAR_W-1:0] c);
        return (c == CH_ZERO) || (c == CH_ONE);
    endfunction

    function automatic logic is_dec(input logic [CHAR_W-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [CHAR_W-1:0] c);
        return is_dec(c) || ((c >= CH_UP_A) && (c <= CH_UP_F))
               || ((c >= CH_LO_A) && (c <= CH_LO_F));
    endfunction

endpackage

>>> src/number_literal_base_classifier_top.sv
// Number literal radix classifier: per-token character scan and registered result.
//
// Usage: a token is sent one character per input item on the slave channel
// (i_s_tdata holds the character, i_s_tlast marks the final one). Characters
// before the final one only update the running scan flags and give no result.
// The final character gives exactly one result item on the master channel:
// the radix (0, 2, 10 or 16), the offset of the first digit, the digit count
// and, in tuser, a flag for tokens longer than MAX_TOKEN_LEN characters.
// The result is registered: it appears in the cycle after the final character is taken.
// Throughput: one character per cycle while no result is stalled, set by the single output register;
// the scan flags and the classification are one level of shallow logic.
// When the receiver stalls, the result is held in the output register and
// o_s_tready drops only while that register is full and not being taken, so
// a new character is still taken in the cycle the held result leaves.
// Reset (synchronous, active low) clears the scan state to the start of a
// new token and empties the output register.
module number_literal_base_classifier_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [nlbc_pkg::CHAR_W-1:0]         i_s_tdata,  // [7:0] char_code
    input  logic                                i_s_tlast,  // last_char
    // Result channel.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [4:0] radix, [6:5] digits_start, [13:7] digits_length, [15:14] zero
    output logic [nlbc_pkg::RES_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tuser   // too_long
);

    // Scan state of the token in progress.
    logic [nlbc_pkg::CNT_W-1:0]  r_count,   n_count;
    logic [nlbc_pkg::CHAR_W-1:0] r_first,   n_first;
    logic [nlbc_pkg::CHAR_W-1:0] r_second,  n_second;
    logic r_all_bin, n_all_bin, r_bin_one, n_bin_one, r_bin_two, n_bin_two;
    logic r_all_dec, n_all_dec;
    logic r_all_hex, n_all_hex, r_hex_one, n_hex_one, r_hex_two, n_hex_two;

    // Output register.
    logic                              r_m_valid;
    logic [nlbc_pkg::RADIX_W-1:0]      r_radix,  n_radix;
    logic [nlbc_pkg::START_W-1:0]      r_start,  n_start;
    logic [nlbc_pkg::LEN_W-1:0]        r_len,    n_len;
    logic                              r_too_long, n_too_long;

    logic s_accept;
    logic c_bin, c_dec, c_hex;
    logic [nlbc_pkg::CHAR_W-1:0] first;
    logic [nlbc_pkg::EXT_W-1:0]  cnt_ext, len_all, len_less1, len_less2;

    assign o_s_tready = !r_m_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign c_bin = nlbc_pkg::is_bin(i_s_tdata);
    assign c_dec = nlbc_pkg::is_dec(i_s_tdata);
    assign c_hex = nlbc_pkg::is_hex(i_s_tdata);

    // Candidate digit lengths: the token length is count + 1.
    assign cnt_ext   = nlbc_pkg::EXT_W'(r_count);
    assign len_all   = cnt_ext + nlbc_pkg::EXT_W'(1);
    assign len_less1 = cnt_ext;
    assign len_less2 = cnt_ext - nlbc_pkg::EXT_W'(1);

    // For a one-character token the first character is the current one.
    assign first = (r_count == '0) ? i_s_tdata : r_first;

    // Scan state update for characters before the final one.
    always_comb begin
        n_count  = r_count;
        n_first  = r_first;
        n_second = r_second;
        n_all_bin = r_all_bin;
        n_bin_one = r_bin_one;
        n_bin_two = r_bin_two;
        n_all_dec = r_all_dec;
        n_all_hex = r_all_hex;
        n_hex_one = r_hex_one;
        n_hex_two = r_hex_two;
        if (r_count == nlbc_pkg::CNT_W'(0)) begin
            n_first = i_s_tdata;
        end
        if (r_count == nlbc_pkg::CNT_W'(1)) begin
            n_second = i_s_tdata;
        end
        n_all_bin = r_all_bin && c_bin;
        n_all_dec = r_all_dec && c_dec;
        n_all_hex = r_all_hex && c_hex;
        if (r_count >= nlbc_pkg::CNT_W'(1)) begin
            n_bin_one = r_bin_one && c_bin;
            n_hex_one = r_hex_one && c_hex;
        end
        if (r_count >= nlbc_pkg::CNT_W'(2)) begin
            n_bin_two = r_bin_two && c_bin;
            n_hex_two = r_hex_two && c_hex;
        end
        if (r_count != nlbc_pkg::CNT_W'(nlbc_pkg::MAX_TOKEN_LEN + 1)) begin
            n_count = r_count + nlbc_pkg::CNT_W'(1);
        end
    end

    // Classification of the token on its final character.
    always_comb begin
        n_radix    = nlbc_pkg::RADIX_NONE;
        n_start    = nlbc_pkg::START_NONE;
        n_len      = '0;
        n_too_long = 1'b0;
        if (r_count >= nlbc_pkg::CNT_W'(nlbc_pkg::MAX_TOKEN_LEN)) begin
            n_too_long = 1'b1;
        end else begin
            // Binary forms: suffix, percent prefix, zero-b prefix.
            if (i_s_tdata == nlbc_pkg::CH_LO_B || i_s_tdata == nlbc_pkg::CH_UP_B) begin
                if (r_count >= nlbc_pkg::CNT_W'(1) && r_all_bin) begin
                    n_radix = nlbc_pkg::RADIX_BIN;
                    n_len   = len_less1[nlbc_pkg::LEN_W-1:0];
                end
            end else if (first == nlbc_pkg::CH_PERCENT) begin
                if (r_count >= nlbc_pkg::CNT_W'(1) && r_bin_one && c_bin) begin
                    n_radix = nlbc_pkg::RADIX_BIN;
                    n_start = nlbc_pkg::START_MARK;
                    n_len   = len_less1[nlbc_pkg::LEN_W-1:0];
                end
            end else if (first == nlbc_pkg::CH_ZERO) begin
                if (r_count >= nlbc_pkg::CNT_W'(2)
                    && (r_second == nlbc_pkg::CH_LO_B || r_second == nlbc_pkg::CH_UP_B)
                    && r_bin_two && c_bin) begin
                    n_radix = nlbc_pkg::RADIX_BIN;
                    n_start = nlbc_pkg::START_PREFIX;
                    n_len   = len_less2[nlbc_pkg::LEN_W-1:0];
                end
            end

            // Decimal: every character a digit.
            if (n_radix == nlbc_pkg::RADIX_NONE && r_all_dec && c_dec) begin
                n_radix = nlbc_pkg::RADIX_DEC;
                n_start = nlbc_pkg::START_NONE;
                n_len   = len_all[nlbc_pkg::LEN_W-1:0];
            end

            // Hexadecimal forms: suffix, dollar prefix, zero-x prefix.
            if (n_radix == nlbc_pkg::RADIX_NONE) begin
                if (i_s_tdata == nlbc_pkg::CH_LO_H || i_s_tdata == nlbc_pkg::CH_UP_H) begin
                    if (r_count >= nlbc_pkg::CNT_W'(1) && r_all_hex) begin
                        n_radix = nlbc_pkg::RADIX_HEX;
                        n_len   = len_less1[nlbc_pkg::LEN_W-1:0];
                    end
                end else if (first == nlbc_pkg::CH_DOLLAR) begin
                    if (r_count >= nlbc_pkg::CNT_W'(1) && r_hex_one && c_hex) begin
                        n_radix = nlbc_pkg::RADIX_HEX;
                        n_start = nlbc_pkg::START_MARK;
                        n_len   = len_less1[nlbc_pkg::LEN_W-1:0];
                    end
                end else if (first == nlbc_pkg::CH_ZERO) begin
                    if (r_count >= nlbc_pkg::CNT_W'(2)
                        && (r_second == nlbc_pkg::CH_LO_X || r_second == nlbc_pkg::CH_UP_X)
                        && r_hex_two && c_hex) begin
                        n_radix = nlbc_pkg::RADIX_HEX;
                        n_start = nlbc_pkg::START_PREFIX;
                        n_len   = len_less2[nlbc_pkg::LEN_W-1:0];
                    end
                end
            end
        end
    end

    // Scan state registers: a final character returns them to the token start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_accept && i_s_tlast)) begin
            r_count   <= '0;
            r_first   <= '0;
            r_second  <= '0;
            r_all_bin <= 1'b1;
            r_bin_one <= 1'b1;
            r_bin_two <= 1'b1;
            r_all_dec <= 1'b1;
            r_all_hex <= 1'b1;
            r_hex_one <= 1'b1;
            r_hex_two <= 1'b1;
        end else if (s_accept) begin
            r_count   <= n_count;
            r_first   <= n_first;
            r_second  <= n_second;
            r_all_bin <= n_all_bin;
            r_bin_one <= n_bin_one;
            r_bin_two <= n_bin_two;
            r_all_dec <= n_all_dec;
            r_all_hex <= n_all_hex;
            r_hex_one <= n_hex_one;
            r_hex_two <= n_hex_two;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_accept && i_s_tlast) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // Output payload, loaded with each token result.
    always_ff @(posedge i_clk) begin
        if (s_accept && i_s_tlast) begin
            r_radix    <= n_radix;
            r_start    <= n_start;
            r_len      <= n_len;
            r_too_long <= n_too_long;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = nlbc_pkg::RES_TDATA_W'({r_len, r_start, r_radix});
    assign o_m_tuser  = r_too_long;

endmodule

>>> src/nlbc_checker.sv
// Port-level assertions of the number literal classifier and their bind to the top level.
module nlbc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             i_s_tlast,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [nlbc_pkg::RES_TDATA_W-1:0] o_m_tdata,
    input logic                             o_m_tuser
);

    // A stalled result stays valid and unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // A character other than the final one never brings up a new result.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !i_s_tlast && (!o_m_tvalid || i_m_tready)
        |=> !o_m_tvalid)
        else $error("result without final character");

    // Radix is one of the defined codes.
    a_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[4:0] == nlbc_pkg::RADIX_NONE)
                    || (o_m_tdata[4:0] == nlbc_pkg::RADIX_BIN)
                    || (o_m_tdata[4:0] == nlbc_pkg::RADIX_DEC)
                    || (o_m_tdata[4:0] == nlbc_pkg::RADIX_HEX))
        else $error("illegal radix");

    // Not a number, or too long, means empty digit fields.
    a_none_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser || o_m_tdata[4:0] == nlbc_pkg::RADIX_NONE)
        |-> o_m_tdata == '0)
        else $error("digit fields set without a radix");

endmodule

bind number_literal_base_classifier_top nlbc_checker u_nlbc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
